// File: rtl/core/rcps_pkg.sv
// ----------------------------------------------------------------------------
// rcps_pkg
// Types and constants shared by the reverse-complement palindrome scan:
// request and response payloads, register indexes, compare modes, and the
// controller-to-datapath command and status groups.
// ----------------------------------------------------------------------------
package rcps_pkg;

   localparam int unsigned POS_W  = 7;
   localparam int unsigned CODE_W = 3;
   localparam int unsigned CSR_W  = 7;
   localparam int unsigned CIDX_W = 2;

   localparam logic [CIDX_W-1:0] CSR_MIN_LENGTH   = 2'd0;
   localparam logic [CIDX_W-1:0] CSR_COMPARE_MODE = 2'd1;

   localparam logic [1:0] MODE_EQ = 2'd0;
   localparam logic [1:0] MODE_GE = 2'd1;
   localparam logic [1:0] MODE_LE = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0] base_code;
      logic              final_base;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pal_length;
      logic [POS_W-1:0] start_pos;
      logic [POS_W-1:0] end_pos;
      logic             scan_done;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,
      ST_READ,
      ST_CMP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;        // store the request's base
      logic rd;          // read the two bases around the current gap
      logic h_inc;       // the pair matched, widen the run
      logic emit;        // send this gap's result and move to the next gap
      logic emit_single; // send the result for a one-base sequence
   } cmd_type;

   typedef struct packed {
      logic n_lt2;
      logic bound_ok;
      logic pair_ok;
      logic last_gap;
   } status_type;

endpackage

// File: rtl/core/rcps_ctrl.sv
// ----------------------------------------------------------------------------
// rcps_ctrl
// Sequencer for loading and scanning: accepts requests while idle, then walks
// each gap outward one base pair per read/compare step and emits its result.
// ----------------------------------------------------------------------------
module rcps_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                final_base,
   input  rcps_pkg::status_type status,
   output rcps_pkg::cmd_type   cmd,
   output logic                busy
);

   rcps_pkg::state_type state_ff;
   rcps_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rcps_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = (state_ff != rcps_pkg::ST_IDLE);
      unique case (state_ff)
         rcps_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (final_base) begin
                  state_in = rcps_pkg::ST_INIT;
               end
            end
         end
         rcps_pkg::ST_INIT: begin
            if (status.n_lt2) begin
               cmd.emit_single = 1'b1;
               state_in        = rcps_pkg::ST_IDLE;
            end else begin
               state_in = rcps_pkg::ST_READ;
            end
         end
         rcps_pkg::ST_READ: begin
            // Stop growing once the run reaches either end of the sequence.
            if (status.bound_ok) begin
               cmd.rd   = 1'b1;
               state_in = rcps_pkg::ST_CMP;
            end else begin
               state_in = rcps_pkg::ST_EMIT;
            end
         end
         rcps_pkg::ST_CMP: begin
            if (status.pair_ok) begin
               cmd.h_inc = 1'b1;
               state_in  = rcps_pkg::ST_READ;
            end else begin
               state_in = rcps_pkg::ST_EMIT;
            end
         end
         rcps_pkg::ST_EMIT: begin
            cmd.emit = 1'b1;
            state_in = status.last_gap ? rcps_pkg::ST_IDLE : rcps_pkg::ST_READ;
         end
         default: begin
            state_in = rcps_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/rcps_dpath.sv
// ----------------------------------------------------------------------------
// rcps_dpath
// Base store, gap and half-length counters, pairing test, length test and
// the registered response.
// ----------------------------------------------------------------------------
module rcps_dpath #(
   parameter int unsigned SEQ_DEPTH = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rcps_pkg::cmd_type                  cmd,
   input  rcps_pkg::req_type                  req_data,
   input  logic                               csr_we,
   input  logic [rcps_pkg::CIDX_W-1:0]        csr_index,
   input  logic [rcps_pkg::CSR_W-1:0]         csr_wdata,
   output rcps_pkg::status_type               status,
   output logic                               rsp_strobe,
   output rcps_pkg::rsp_type                  rsp_data
);

   localparam int unsigned ADDR_W = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
   localparam logic [rcps_pkg::POS_W-1:0] DEPTH_V = rcps_pkg::POS_W'(SEQ_DEPTH);

   logic [rcps_pkg::CODE_W-1:0] base_store_ff [SEQ_DEPTH];

   logic [rcps_pkg::POS_W-1:0] count_ff, count_in;
   logic [rcps_pkg::POS_W-1:0] n_ff, n_in;
   logic [rcps_pkg::POS_W-1:0] gap_ff, gap_in;
   logic [rcps_pkg::POS_W-1:0] h_ff, h_in;
   logic [rcps_pkg::POS_W-1:0] min_length_ff;
   logic [1:0]                 compare_mode_ff;
   logic [rcps_pkg::CODE_W-1:0] left_ff, right_ff;
   logic                       rsp_strobe_ff;
   rcps_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       has_room;
   logic [rcps_pkg::POS_W-1:0] left_pos;
   logic [rcps_pkg::POS_W-1:0] right_pos;
   logic [rcps_pkg::POS_W-1:0] pal_len;
   logic [rcps_pkg::POS_W-1:0] thr;
   logic                       pass;

   assign has_room  = (count_ff < DEPTH_V);
   assign left_pos  = gap_ff - h_ff;
   assign right_pos = gap_ff + 7'd1 + h_ff;
   assign pal_len   = {h_ff[rcps_pkg::POS_W-2:0], 1'b0};
   assign thr       = (min_length_ff > DEPTH_V) ? DEPTH_V : min_length_ff;

   always_comb begin
      unique case (compare_mode_ff)
         rcps_pkg::MODE_EQ: pass = (pal_len == thr);
         rcps_pkg::MODE_GE: pass = (pal_len >= thr);
         rcps_pkg::MODE_LE: pass = (pal_len <= thr) && (pal_len != '0);
         default:           pass = 1'b0;
      endcase
   end

   // Complementary codes differ in both low bits (A/T and C/G); codes of
   // four and up never pair.
   assign status.pair_ok  = !left_ff[2] && !right_ff[2] && ((left_ff[1:0] ^ right_ff[1:0]) == 2'b11);
   assign status.bound_ok = (h_ff <= gap_ff) && (right_pos < n_ff);
   assign status.n_lt2    = (n_ff < 7'd2);
   assign status.last_gap = ((gap_ff + 7'd2) == n_ff);

   always_comb begin
      count_in = count_ff;
      n_in     = n_ff;
      gap_in   = gap_ff;
      h_in     = h_ff;
      if (cmd.load) begin
         if (req_data.final_base) begin
            n_in     = has_room ? count_ff + 7'd1 : count_ff;
            count_in = '0;
            gap_in   = '0;
            h_in     = '0;
         end else if (has_room) begin
            count_in = count_ff + 7'd1;
         end
      end
      if (cmd.h_inc) begin
         h_in = h_ff + 7'd1;
      end
      if (cmd.emit) begin
         gap_in = gap_ff + 7'd1;
         h_in   = '0;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.emit_single) begin
         rsp_in.hit        = 1'b0;
         rsp_in.pal_length = '0;
         rsp_in.start_pos  = 7'd1;
         rsp_in.end_pos    = '0;
         rsp_in.scan_done  = 1'b1;
      end else if (cmd.emit) begin
         rsp_in.hit        = pass;
         rsp_in.pal_length = pal_len;
         rsp_in.start_pos  = left_pos + 7'd2;
         rsp_in.end_pos    = right_pos;
         rsp_in.scan_done  = status.last_gap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff        <= '0;
         n_ff            <= '0;
         gap_ff          <= '0;
         h_ff            <= '0;
         min_length_ff   <= '0;
         compare_mode_ff <= rcps_pkg::MODE_GE;
         rsp_strobe_ff   <= 1'b0;
      end else begin
         count_ff      <= count_in;
         n_ff          <= n_in;
         gap_ff        <= gap_in;
         h_ff          <= h_in;
         rsp_strobe_ff <= cmd.emit || cmd.emit_single;
         if (csr_we) begin
            if (csr_index == rcps_pkg::CSR_MIN_LENGTH) begin
               min_length_ff <= csr_wdata;
            end else if (csr_index == rcps_pkg::CSR_COMPARE_MODE) begin
               compare_mode_ff <= csr_wdata[1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (cmd.load && has_room) begin
         base_store_ff[count_ff[ADDR_W-1:0]] <= req_data.base_code;
      end
      if (cmd.rd) begin
         left_ff  <= base_store_ff[left_pos[ADDR_W-1:0]];
         right_ff <= base_store_ff[right_pos[ADDR_W-1:0]];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// File: rtl/core/reverse_complement_palindrome_scan.sv
// ----------------------------------------------------------------------------
// reverse_complement_palindrome_scan
// Loads a coded DNA sequence one base per request, then reports the even
// reverse-complement palindrome around every gap between neighboring bases.
// ----------------------------------------------------------------------------
// Requests are accepted while idle; a request flagged final_base starts the scan.
// Scan: a setup step, then per gap a read and a compare for each base pair until
// the run reaches an end of the sequence or a pair fails, then an emit step. Each
// result is on the ports in the cycle after its gap's emit step; busy falls with
// the last emit, so the final result shows in the first idle cycle, never stalled.
// Synchronous reset empties the sequence and sets min_length 0, compare_mode 1.
module reverse_complement_palindrome_scan #(
   parameter int unsigned SEQ_DEPTH = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  rcps_pkg::req_type           req_data,
   output logic                        rsp_strobe,
   output rcps_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [rcps_pkg::CIDX_W-1:0] csr_index,
   input  logic [rcps_pkg::CSR_W-1:0]  csr_wdata
);

   rcps_pkg::cmd_type    cmd;
   rcps_pkg::status_type status;

   rcps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .final_base (req_data.final_base),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   rcps_dpath #(
      .SEQ_DEPTH (SEQ_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// File: rtl/core/rcps_checker.sv
// ----------------------------------------------------------------------------
// rcps_checker
// Port-level checks on the palindrome scan, bound to the top level.
// ----------------------------------------------------------------------------
module rcps_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input rcps_pkg::req_type req_data,
   input logic              rsp_strobe,
   input rcps_pkg::rsp_type rsp_data
);

   // Reset leaves the block idle with no response pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or response strobe right after reset");

   // A base that does not end the sequence never produces a response.
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_data.final_base) |=> !rsp_strobe)
      else $error("response after a loading request");

   // The end of a scan is followed by a quiet cycle.
   a_done_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.scan_done) |=> !rsp_strobe)
      else $error("response right after the end of a scan");

   // The reported run spans exactly its length and is even.
   a_span: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_data.end_pos + 7'd1) == (rsp_data.start_pos + rsp_data.pal_length))
                     && !rsp_data.pal_length[0])
      else $error("response positions disagree with length");

endmodule

bind reverse_complement_palindrome_scan rcps_checker u_rcps_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

// File: tb/reverse_complement_palindrome_scan_tb.sv
// ----------------------------------------------------------------------------
// reverse_complement_palindrome_scan_tb
// Sends coded DNA sequences to the palindrome scanner and predicts the result
// for every gap between neighboring bases. Each strobed result is checked
// field by field against the oldest prediction. A short directed part covers
// one-base sequences, every base code, every compare mode, saturated
// thresholds and writes to unused register indexes. A random part follows with
// mostly short sequences that hold planted reverse-complement runs, a few full
// and overflowing ones, threshold changes between scans, and random idle gaps.
// ----------------------------------------------------------------------------
module reverse_complement_palindrome_scan_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rcps_pkg::*;

   localparam int unsigned SEQ_DEPTH    = 64;
   localparam int unsigned RANDOM_ITEMS = 280;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   localparam logic [CIDX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CIDX_W-1:0] CSR_SPARE_3 = 2'd3;
   localparam logic [1:0]        MODE_NONE   = 2'd3;

   localparam logic [CODE_W-1:0] BASE_A = 3'd0;
   localparam logic [CODE_W-1:0] BASE_C = 3'd1;
   localparam logic [CODE_W-1:0] BASE_G = 3'd2;
   localparam logic [CODE_W-1:0] BASE_T = 3'd3;
   localparam logic [CODE_W-1:0] BASE_N = 3'd4;

   logic              clock = 1'b0;
   logic              reset;
   logic              start;
   logic              busy;
   req_type           req_data;
   logic              rsp_strobe;
   rsp_type           rsp_data;
   logic              csr_we;
   logic [CIDX_W-1:0] csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   logic [CODE_W-1:0] seq_buf [0:79];
   int unsigned       seq_len;
   bit                no_idle;
   int unsigned       cycles;

   class palindrome_scoreboard;
      logic [CODE_W-1:0] bases [SEQ_DEPTH];
      int unsigned       held;
      logic [POS_W-1:0]  min_len;
      logic [1:0]        mode;
      rsp_type           expected_gaps [$];
      int unsigned       mismatches;

      function new();
         held = 0;
         min_len = '0;
         mode = MODE_GE;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CIDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == CSR_MIN_LENGTH) begin
            min_len = data;
         end else if (idx == CSR_COMPARE_MODE) begin
            mode = data[1:0];
         end
      endfunction

      function bit complements(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
         return a <= BASE_T && b <= BASE_T && (a + b) == 3;
      endfunction

      function bit passes_length(int unsigned len);
         int unsigned thr;
         thr = (min_len > SEQ_DEPTH) ? SEQ_DEPTH : min_len;
         case (mode)
            MODE_EQ: return len == thr;
            MODE_GE: return len >= thr;
            MODE_LE: return len <= thr && len > 0;
            default: return 1'b0;
         endcase
      endfunction

      function void note_request(req_type r);
         int unsigned n;
         int unsigned h;
         rsp_type     e;
         if (held < SEQ_DEPTH) begin
            bases[held] = r.base_code;
            held++;
         end
         if (!r.final_base) return;
         n = held;
         held = 0;
         if (n < 2) begin
            e = '{hit: 1'b0, pal_length: '0, start_pos: 7'd1, end_pos: '0, scan_done: 1'b1};
            expected_gaps.push_back(e);
            return;
         end
         for (int unsigned g = 0; g + 1 < n; g++) begin
            h = 0;
            while (h <= g && g + 1 + h < n && complements(bases[g - h], bases[g + 1 + h]))
               h++;
            e.hit        = passes_length(2 * h);
            e.pal_length = POS_W'(2 * h);
            e.start_pos  = POS_W'(g - h + 2);
            e.end_pos    = POS_W'(g + h + 1);
            e.scan_done  = (g + 2 == n);
            expected_gaps.push_back(e);
         end
      endfunction

      function void check_response(rsp_type got);
         rsp_type e;
         if (expected_gaps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("error: result with nothing pending: hit=%0d len=%0d start=%0d end=%0d done=%0d",
                        got.hit, got.pal_length, got.start_pos, got.end_pos, got.scan_done);
            return;
         end
         e = expected_gaps.pop_front();
         if (got.hit !== e.hit || got.pal_length !== e.pal_length ||
             got.start_pos !== e.start_pos || got.end_pos !== e.end_pos ||
             got.scan_done !== e.scan_done) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("error: expected hit=%0d len=%0d start=%0d end=%0d done=%0d",
                        e.hit, e.pal_length, e.start_pos, e.end_pos, e.scan_done);
               $display("       actual   hit=%0d len=%0d start=%0d end=%0d done=%0d",
                        got.hit, got.pal_length, got.start_pos, got.end_pos, got.scan_done);
            end
         end
      endfunction
   endclass

   palindrome_scoreboard sb;

   reverse_complement_palindrome_scan #(.SEQ_DEPTH(SEQ_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Everything is sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      cycles++;
      if (!reset) begin
         if (csr_we) sb.write_reg(csr_index, csr_wdata);
         if (start && !busy) sb.note_request(req_data);
         if (rsp_strobe) sb.check_response(rsp_data);
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int unsigned idle_gap();
      int unsigned r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_base(input logic [CODE_W-1:0] code, input logic last);
      int unsigned gap;
      req_data <= req_type'{base_code: code, final_base: last};
      start <= 1'b1;
      do @(posedge clock); while (busy);
      gap = idle_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Registers are only touched once the scan is over and the block is idle.
   task automatic quiesce();
      start <= 1'b0;
      @(posedge clock);
      while (sb.expected_gaps.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csrs(input logic [CSR_W-1:0] min_len, input logic [1:0] mode,
                             input bit with_spare);
      csr_we <= 1'b1;
      csr_index <= CSR_MIN_LENGTH;
      csr_wdata <= min_len;
      @(posedge clock);
      csr_index <= CSR_COMPARE_MODE;
      csr_wdata <= {5'($urandom_range(0, 31)), mode};
      @(posedge clock);
      if (with_spare) begin
         csr_index <= $urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3;
         csr_wdata <= CSR_W'($urandom_range(0, 127));
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic void build_sequence(int unsigned n, bit repeat_pair);
      int unsigned       c;
      int unsigned       k;
      int unsigned       span;
      logic [CODE_W-1:0] x;
      seq_len = n;
      x = CODE_W'($urandom_range(0, 3));
      for (int unsigned i = 0; i < n; i++) begin
         if (repeat_pair) seq_buf[i] = i[0] ? BASE_T - x : x;
         else if ($urandom_range(0, 9) == 0) seq_buf[i] = CODE_W'($urandom_range(4, 7));
         else seq_buf[i] = CODE_W'($urandom_range(0, 3));
      end
      // Plant a reverse-complement run around a random gap, now and then with one
      // damaged base, so that most scans see runs longer than chance would give.
      if (!repeat_pair && n >= 2 && $urandom_range(0, 3) != 0) begin
         c = $urandom_range(0, n - 2);
         span = (c + 1 < n - 1 - c) ? c + 1 : n - 1 - c;
         k = $urandom_range(1, span);
         for (int unsigned i = 0; i < k; i++) begin
            if (seq_buf[c - i] > BASE_T) seq_buf[c - i] = CODE_W'($urandom_range(0, 3));
            seq_buf[c + 1 + i] = BASE_T - seq_buf[c - i];
         end
         if ($urandom_range(0, 4) == 0)
            seq_buf[$urandom_range(0, n - 1)] = CODE_W'($urandom_range(0, 7));
      end
   endfunction

   initial begin
      int unsigned      sent;
      int unsigned      seq_index;
      int unsigned      n;
      int unsigned      r;
      logic [CSR_W-1:0] threshold;
      logic [1:0]       mode_sel;
      sb = new();
      cycles = 0;
      no_idle = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      write_csrs(7'd0, MODE_GE, 1'b1);
      send_base(BASE_A, 1'b1);
      send_base(BASE_A, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_G, 1'b0);
      send_base(BASE_T, 1'b1);

      quiesce();
      write_csrs(7'd4, MODE_EQ, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_A, 1'b0);
      send_base(BASE_T, 1'b0);
      send_base(BASE_G, 1'b1);

      // Threshold above the store depth saturates; unknown codes never pair.
      quiesce();
      write_csrs(7'd127, MODE_LE, 1'b1);
      send_base(BASE_N | BASE_C, 1'b0);
      send_base(BASE_N | BASE_G, 1'b0);
      send_base(~BASE_A, 1'b0);
      send_base(BASE_N, 1'b1);
      send_base(BASE_A, 1'b0);
      send_base(BASE_T, 1'b1);

      quiesce();
      write_csrs(7'd2, MODE_NONE, 1'b0);
      send_base(BASE_G, 1'b0);
      send_base(BASE_C, 1'b0);
      send_base(BASE_G, 1'b0);
      send_base(BASE_C, 1'b1);

      quiesce();
      write_csrs(7'd64, MODE_GE, 1'b1);
      send_base(BASE_T, 1'b0);
      send_base(BASE_A, 1'b1);

      sent = 0;
      seq_index = 0;
      while (sent < RANDOM_ITEMS) begin
         if (seq_index > 0 && $urandom_range(0, 4) == 0) begin
            quiesce();
            case ($urandom_range(0, 5))
               0: threshold = 7'd0;
               1: threshold = 7'd64;
               2: threshold = 7'd127;
               3: threshold = CSR_W'($urandom_range(65, 126));
               default: threshold = CSR_W'(2 * $urandom_range(0, 12));
            endcase
            mode_sel = ($urandom_range(0, 7) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
            write_csrs(threshold, mode_sel, $urandom_range(0, 3) == 0);
         end
         no_idle = ($urandom_range(0, 3) == 0);
         r = $urandom_range(0, 99);
         // One full store and one overflowing sequence, both of the deepest kind.
         if (seq_index == 2) n = SEQ_DEPTH;
         else if (seq_index == 5) n = SEQ_DEPTH + 6;
         else if (r < 8) n = 1;
         else if (r < 80) n = $urandom_range(2, 10);
         else if (r < 95) n = $urandom_range(11, 32);
         else n = $urandom_range(33, 72);
         build_sequence(n, seq_index == 2 || seq_index == 5 || $urandom_range(0, 9) == 0);
         for (int unsigned i = 0; i < seq_len; i++)
            send_base(seq_buf[i], i == seq_len - 1);
         sent += n;
         seq_index++;
      end

      quiesce();
      repeat (16) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_gaps.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/core/rcps_pkg.sv
rtl/core/rcps_ctrl.sv
rtl/core/rcps_dpath.sv
rtl/core/reverse_complement_palindrome_scan.sv
rtl/core/rcps_checker.sv
tb/reverse_complement_palindrome_scan_tb.sv
